### hw/rtl/cbb_pkg.sv
// Shared types and constants for the cubic Bezier bounding box block.
// Used by every module in hw/rtl; depends on nothing.
package cbb_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    // coordinate and coefficient widths (exact for any 32-bit input)
    localparam int P_W   = 32;
    localparam int CA_W  = 36;   // 3(p1-p2)+p3-p0
    localparam int CB_W  = 35;   // p0-2p1+p2
    localparam int CC_W  = 33;   // p1-p0
    localparam int N_W   = 38;   // root numerator -B +/- S, signed
    localparam int N_MAG_W = 37; // numerator magnitude bits
    localparam int EA_W  = 40;   // cubic evaluation accumulator, signed

    // iterative unit
    localparam int IT_W       = 76;
    localparam int SQ_IN_W    = 72;
    localparam int MUL_STEPS  = 36;
    localparam int SQRT_STEPS = 36;

    localparam int QUEUE_DEPTH = 2;

    localparam logic signed [P_W-1:0] ACC_MIN_INIT = 32'sh7FFF_FFFF;
    localparam logic signed [P_W-1:0] ACC_MAX_INIT = 32'sh8000_0000;

    typedef struct packed {
        logic signed [P_W-1:0] start_x;
        logic signed [P_W-1:0] start_y;
        logic signed [P_W-1:0] ctrl1_x;
        logic signed [P_W-1:0] ctrl1_y;
        logic signed [P_W-1:0] ctrl2_x;
        logic signed [P_W-1:0] ctrl2_y;
        logic signed [P_W-1:0] finish_x;
        logic signed [P_W-1:0] finish_y;
        logic                  last_curve;
    } curve_t;

    typedef struct packed {
        logic signed [P_W-1:0] box_min_x;
        logic signed [P_W-1:0] box_min_y;
        logic signed [P_W-1:0] box_max_x;
        logic signed [P_W-1:0] box_max_y;
    } box_t;

    typedef struct packed {
        logic signed [P_W-1:0]  p0;
        logic signed [P_W-1:0]  p3;
        logic signed [CA_W-1:0] ca;
        logic signed [CB_W-1:0] cb;
        logic signed [CC_W-1:0] cc;
        logic                   a_zero;
        logic                   b_zero;
        logic                   c_zero;
    } axis_job_t;

    typedef struct packed {
        axis_job_t x;
        axis_job_t y;
        logic      last;
    } job_t;

    typedef enum logic [1:0] {
        IT_MUL,
        IT_DIV,
        IT_SQRT
    } iter_op_t;

    typedef struct packed {
        logic            start;
        iter_op_t        op;
        logic [IT_W-1:0] a;
        logic [IT_W-1:0] b;
    } iter_req_t;

    typedef struct packed {
        logic            done;
        logic [IT_W-1:0] result;
    } iter_rsp_t;

endpackage

### hw/rtl/cubic_bezier_bounding_box.sv
// Running bounding box of cubic Bezier curves: top level.
// Instantiates cbb_front, cbb_fifo, cbb_back and cbb_iter; depends on cbb_pkg.
//
// Usage: send one curve request per handshake on curve (valid/stall); the
// box widens to hold each curve. On a request with last_curve set, one box
// result leaves on box (valid/stall) and the running box starts over.
// Requests without last_curve give no result.
//
// Flow: the front registers the curve coefficients and queues up to two
// jobs. The back works one axis after the other on a single shared iterative unit.
//
// Reset clears the queue and returns the box to its empty value (min at
// the most positive, max at the most negative code). While box is stalled
// the result holds in its register; the back keeps working on later curves
// and waits only when a second box is ready. A full queue stalls curve.
module cubic_bezier_bounding_box #(
    parameter int FRACTION_BITS = cbb_pkg::FRACTION_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            curve_valid,
    output logic            curve_stall,
    input  cbb_pkg::curve_t curve,
    output logic            box_valid,
    input  logic            box_stall,
    output cbb_pkg::box_t   box
);
    import cbb_pkg::*;

    // front to queue
    logic      fj_valid;
    logic      fj_stall;
    job_t      fj;
    // queue to back
    logic      qj_valid;
    logic      qj_pop;
    job_t      qj;
    // back to shared arithmetic unit
    iter_req_t it_req;
    iter_rsp_t it_rsp;

    // classify: derivative coefficients and their zero flags
    cbb_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .curve_valid (curve_valid),
        .curve_stall (curve_stall),
        .curve       (curve),
        .job_valid   (fj_valid),
        .job_stall   (fj_stall),
        .job         (fj)
    );

    // decouple front and back so each can stall on its own
    cbb_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fj_valid),
        .push_stall (fj_stall),
        .push_job   (fj),
        .pop_valid  (qj_valid),
        .pop        (qj_pop),
        .pop_job    (qj)
    );

    // root search, evaluation, box fold and result register
    cbb_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qj_valid),
        .job_pop   (qj_pop),
        .job       (qj),
        .it_req    (it_req),
        .it_rsp    (it_rsp),
        .box_valid (box_valid),
        .box_stall (box_stall),
        .box       (box)
    );

    // one multiply / divide / square root in flight at a time
    cbb_iter #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_iter (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (it_req),
        .rsp   (it_rsp)
    );

endmodule

### hw/rtl/cbb_front.sv
// Front end: accepts curve requests and registers the derivative coefficients.
// Depends on cbb_pkg.
module cbb_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            curve_valid,
    output logic            curve_stall,
    input  cbb_pkg::curve_t curve,
    output logic            job_valid,
    input  logic            job_stall,
    output cbb_pkg::job_t   job
);
    import cbb_pkg::*;

    job_t job_reg;
    job_t job_next;
    logic job_valid_reg;

    function automatic axis_job_t make_axis(logic signed [P_W-1:0] p0,
                                            logic signed [P_W-1:0] p1,
                                            logic signed [P_W-1:0] p2,
                                            logic signed [P_W-1:0] p3);
        logic signed [CA_W-1:0] e0;
        logic signed [CA_W-1:0] e1;
        logic signed [CA_W-1:0] e2;
        logic signed [CA_W-1:0] e3;
        logic signed [CA_W-1:0] d12;
        logic signed [CA_W-1:0] ca;
        logic signed [CA_W-1:0] cb;
        logic signed [CA_W-1:0] cc;
        axis_job_t              r;
        e0  = CA_W'(p0);
        e1  = CA_W'(p1);
        e2  = CA_W'(p2);
        e3  = CA_W'(p3);
        d12 = e1 - e2;
        ca  = (d12 <<< 1) + d12 + e3 - e0;
        cb  = e0 - (e1 <<< 1) + e2;
        cc  = e1 - e0;
        r.p0     = p0;
        r.p3     = p3;
        r.ca     = ca;
        r.cb     = cb[CB_W-1:0];
        r.cc     = cc[CC_W-1:0];
        r.a_zero = (ca == '0);
        r.b_zero = (cb == '0);
        r.c_zero = (cc == '0);
        return r;
    endfunction

    always_comb
    begin
        job_next.x    = make_axis(curve.start_x, curve.ctrl1_x, curve.ctrl2_x, curve.finish_x);
        job_next.y    = make_axis(curve.start_y, curve.ctrl1_y, curve.ctrl2_y, curve.finish_y);
        job_next.last = curve.last_curve;
    end

    // hold the request while the queue is full
    assign curve_stall = job_valid_reg && job_stall;
    assign job_valid   = job_valid_reg;
    assign job         = job_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
        end
        else if (!curve_stall)
        begin
            job_valid_reg <= curve_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!curve_stall && curve_valid)
        begin
            job_reg <= job_next;
        end
    end

endmodule

### hw/rtl/cbb_fifo.sv
// Short queue of classified curve jobs between front and back end.
// Depends on cbb_pkg.
module cbb_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_stall,
    input  cbb_pkg::job_t push_job,
    output logic          pop_valid,
    input  logic          pop,
    output cbb_pkg::job_t pop_job
);
    import cbb_pkg::*;

    localparam int QP_W = $clog2(QUEUE_DEPTH);

    job_t             mem_reg [QUEUE_DEPTH];
    logic [QP_W-1:0]  wr_ptr_reg;
    logic [QP_W-1:0]  rd_ptr_reg;
    logic [QP_W:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_stall = (count_reg == (QP_W+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && !push_stall;
    assign do_pop     = pop && pop_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### hw/rtl/cbb_iter.sv
// Shared iterative arithmetic unit: shift-add multiply, restoring divide,
// digit-by-digit square root, one bit (or bit pair) per cycle. Depends on cbb_pkg.
module cbb_iter #(
    parameter int FRACTION_BITS = cbb_pkg::FRACTION_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  cbb_pkg::iter_req_t req,
    output cbb_pkg::iter_rsp_t rsp
);
    import cbb_pkg::*;

    localparam int DIV_W    = N_MAG_W + FRACTION_BITS;
    localparam int STEP_MAX = (DIV_W > MUL_STEPS) ? DIV_W : MUL_STEPS;
    localparam int CNT_W    = $clog2(STEP_MAX + 1);

    iter_op_t        op_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_last;
    logic [IT_W-1:0] x_reg;
    logic [IT_W-1:0] y_reg;
    logic [IT_W-1:0] z_reg;
    logic [IT_W-1:0] x_next;
    logic [IT_W-1:0] y_next;
    logic [IT_W-1:0] z_next;
    logic [IT_W-1:0] r2;
    logic [IT_W-1:0] trial;
    logic            ge;

    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        z_next   = z_reg;
        r2       = '0;
        trial    = '0;
        ge       = 1'b0;
        cnt_last = CNT_W'(MUL_STEPS - 1);
        case (op_reg)
            IT_MUL:
            begin
                z_next = (z_reg << 1) + (y_reg[MUL_STEPS-1] ? x_reg : '0);
                y_next = y_reg << 1;
            end
            IT_DIV:
            begin
                cnt_last = CNT_W'(DIV_W - 1);
                r2       = {z_reg[IT_W-2:0], y_reg[DIV_W-1]};
                ge       = (r2 >= x_reg);
                z_next   = ge ? (r2 - x_reg) : r2;
                y_next   = {y_reg[IT_W-2:0], ge};
            end
            IT_SQRT:
            begin
                cnt_last = CNT_W'(SQRT_STEPS - 1);
                r2       = {z_reg[IT_W-3:0], y_reg[SQ_IN_W-1 -: 2]};
                trial    = {x_reg[IT_W-3:0], 2'b01};
                ge       = (r2 >= trial);
                z_next   = ge ? (r2 - trial) : r2;
                x_next   = {x_reg[IT_W-2:0], ge};
                y_next   = y_reg << 2;
            end
            default:
            begin
                x_next = x_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= IT_MUL;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
        end
        else
        begin
            // pulse done on the last step only
            done_reg <= !req.start && busy_reg && (cnt_reg == cnt_last);
            if (req.start)
            begin
                op_reg   <= req.op;
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                z_reg    <= '0;
                y_reg    <= (req.op == IT_MUL) ? req.b : req.a;
                case (req.op)
                    IT_MUL:  x_reg <= req.a;
                    IT_DIV:  x_reg <= req.b;
                    default: x_reg <= '0;
                endcase
            end
            else if (busy_reg)
            begin
                x_reg   <= x_next;
                y_reg   <= y_next;
                z_reg   <= z_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == cnt_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        rsp.done = done_reg;
        case (op_reg)
            IT_MUL:  rsp.result = z_reg;
            IT_DIV:  rsp.result = IT_W'(y_reg[DIV_W-1:0]);
            IT_SQRT: rsp.result = x_reg;
            default: rsp.result = z_reg;
        endcase
    end

endmodule

### hw/rtl/cbb_back.sv
// Back end: per-axis extremum search, cubic evaluation, box accumulation and
// result register. Uses cbb_iter through iter_req_t / iter_rsp_t. Depends on cbb_pkg.
module cbb_back #(
    parameter int FRACTION_BITS = cbb_pkg::FRACTION_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_pop,
    input  cbb_pkg::job_t      job,
    output cbb_pkg::iter_req_t it_req,
    input  cbb_pkg::iter_rsp_t it_rsp,
    output logic               box_valid,
    input  logic               box_stall,
    output cbb_pkg::box_t      box
);
    import cbb_pkg::*;

    localparam int T_W = FRACTION_BITS + 1;
    localparam logic [IT_W-1:0] ONE_W  = IT_W'(1) << FRACTION_BITS;
    localparam logic [T_W-1:0]  T_HALF = T_W'(1) << (FRACTION_BITS - 1);
    localparam logic signed [EA_W-1:0] SAT_HI = EA_W'(ACC_MIN_INIT);
    localparam logic signed [EA_W-1:0] SAT_LO = EA_W'(ACC_MAX_INIT);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ENDS,
        S_MSQ,
        S_MPR,
        S_SQRT,
        S_DSTART,
        S_DIV,
        S_ESTART,
        S_EMUL,
        S_NEXT,
        S_EMIT
    } state_t;

    state_t                 state_reg;
    job_t                   job_reg;
    logic                   axis_reg;
    logic [IT_W-1:0]        sq_reg;
    logic signed [N_W-1:0]  s_reg;
    logic signed [N_W-1:0]  n_reg;
    logic signed [CA_W-1:0] den_reg;
    logic                   root_last_reg;
    logic [T_W-1:0]         t_reg;
    logic signed [EA_W-1:0] eacc_reg;
    logic [1:0]             estep_reg;
    logic signed [P_W-1:0]  min_x_reg;
    logic signed [P_W-1:0]  min_y_reg;
    logic signed [P_W-1:0]  max_x_reg;
    logic signed [P_W-1:0]  max_y_reg;
    box_t                   box_reg;
    logic                   box_valid_reg;
    iter_req_t              it_req_reg;
    logic                   it_start_next;

    axis_job_t              ax;
    logic signed [N_W-1:0]  neg_cb;
    logic signed [N_W-1:0]  neg_cc;
    logic signed [N_W-1:0]  s_n;
    logic signed [CA_W-1:0] two_cb;
    logic [IT_W-1:0]        cb_mag;
    logic [IT_W-1:0]        ca_mag;
    logic [IT_W-1:0]        cc_mag;
    logic [IT_W-1:0]        n_mag;
    logic [IT_W-1:0]        den_mag;
    logic                   prod_neg;
    logic [IT_W-1:0]        d_sum;
    logic [IT_W-1:0]        d_diff;
    logic [IT_W-1:0]        d_val;
    logic                   sq_less;
    logic                   q_neg;
    logic                   q_ok;
    logic [IT_W-1:0]        eacc_mag;
    logic signed [IT_W:0]   prod_s;
    logic signed [IT_W:0]   prod_sh;
    logic signed [EA_W-1:0] k_add;
    logic signed [EA_W-1:0] eacc_new;
    logic signed [P_W-1:0]  sat_val;
    logic signed [P_W-1:0]  fold_v0;
    logic signed [P_W-1:0]  fold_v1;
    logic signed [P_W-1:0]  cur_lo;
    logic signed [P_W-1:0]  cur_hi;
    logic signed [P_W-1:0]  lo_a;
    logic signed [P_W-1:0]  hi_a;
    logic signed [P_W-1:0]  lo_new;
    logic signed [P_W-1:0]  hi_new;

    always_comb
    begin
        ax      = axis_reg ? job_reg.y : job_reg.x;
        neg_cb  = -N_W'(ax.cb);
        neg_cc  = -N_W'(ax.cc);
        s_n     = s_reg;
        two_cb  = CA_W'(ax.cb) <<< 1;
        cb_mag  = IT_W'(ax.cb[CB_W-1] ? -N_W'(ax.cb) : N_W'(ax.cb));
        ca_mag  = IT_W'(ax.ca[CA_W-1] ? -N_W'(ax.ca) : N_W'(ax.ca));
        cc_mag  = IT_W'(ax.cc[CC_W-1] ? -N_W'(ax.cc) : N_W'(ax.cc));
        n_mag   = IT_W'(n_reg[N_W-1] ? -n_reg : n_reg) << FRACTION_BITS;
        den_mag = IT_W'(den_reg[CA_W-1] ? -N_W'(den_reg) : N_W'(den_reg));

        // discriminant B*B - A*C from the two products
        prod_neg = (ax.ca[CA_W-1] != ax.cc[CC_W-1]) && !ax.c_zero;
        d_sum    = sq_reg + it_rsp.result;
        d_diff   = sq_reg - it_rsp.result;
        sq_less  = (sq_reg < it_rsp.result);
        d_val    = prod_neg ? d_sum : d_diff;

        // a root is kept when it truncates into [0, 1]
        q_neg = (n_reg[N_W-1] != den_reg[CA_W-1]);
        q_ok  = (it_rsp.result == '0) || (!q_neg && (it_rsp.result <= ONE_W));

        // one Horner step: floor(acc * t / 2^F) + next coefficient
        eacc_mag = IT_W'(eacc_reg[EA_W-1] ? -eacc_reg : eacc_reg);
        prod_s   = eacc_reg[EA_W-1] ? -$signed({1'b0, it_rsp.result})
                                    : $signed({1'b0, it_rsp.result});
        prod_sh  = prod_s >>> FRACTION_BITS;
        case (estep_reg)
            2'd0:    k_add = (EA_W'(ax.cb) <<< 1) + EA_W'(ax.cb);
            2'd1:    k_add = (EA_W'(ax.cc) <<< 1) + EA_W'(ax.cc);
            default: k_add = EA_W'(ax.p0);
        endcase
        eacc_new = prod_sh[EA_W-1:0] + k_add;
        if (eacc_new > SAT_HI)
        begin
            sat_val = ACC_MIN_INIT;
        end
        else if (eacc_new < SAT_LO)
        begin
            sat_val = ACC_MAX_INIT;
        end
        else
        begin
            sat_val = eacc_new[P_W-1:0];
        end

        fold_v0 = (state_reg == S_ENDS) ? ax.p0 : sat_val;
        fold_v1 = (state_reg == S_ENDS) ? ax.p3 : sat_val;
        cur_lo  = axis_reg ? min_y_reg : min_x_reg;
        cur_hi  = axis_reg ? max_y_reg : max_x_reg;
        lo_a    = (fold_v0 < cur_lo) ? fold_v0 : cur_lo;
        lo_new  = (fold_v1 < lo_a) ? fold_v1 : lo_a;
        hi_a    = (fold_v0 > cur_hi) ? fold_v0 : cur_hi;
        hi_new  = (fold_v1 > hi_a) ? fold_v1 : hi_a;

        // issue an operation to the shared unit
        case (state_reg)
            S_ENDS:   it_start_next = !ax.a_zero;
            S_MSQ:    it_start_next = it_rsp.done;
            S_MPR:    it_start_next = it_rsp.done && (prod_neg || !sq_less) && (d_val != '0);
            S_DSTART: it_start_next = 1'b1;
            S_ESTART: it_start_next = 1'b1;
            default:  it_start_next = 1'b0;
        endcase
    end

    assign job_pop   = (state_reg == S_IDLE) && job_valid;
    assign it_req    = it_req_reg;
    assign box_valid = box_valid_reg;
    assign box       = box_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            job_reg       <= '0;
            axis_reg      <= 1'b0;
            sq_reg        <= '0;
            s_reg         <= '0;
            n_reg         <= '0;
            den_reg       <= '0;
            root_last_reg <= 1'b0;
            t_reg         <= '0;
            eacc_reg      <= '0;
            estep_reg     <= '0;
            min_x_reg     <= ACC_MIN_INIT;
            min_y_reg     <= ACC_MIN_INIT;
            max_x_reg     <= ACC_MAX_INIT;
            max_y_reg     <= ACC_MAX_INIT;
            box_reg       <= '0;
            box_valid_reg <= 1'b0;
            it_req_reg    <= '0;
        end
        else
        begin
            it_req_reg.start <= it_start_next;
            if (box_valid_reg && !box_stall && (state_reg != S_EMIT))
            begin
                box_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid)
                    begin
                        job_reg   <= job;
                        axis_reg  <= 1'b0;
                        state_reg <= S_ENDS;
                    end
                end

                S_ENDS:
                begin
                    // end points first, then pick the derivative case
                    if (axis_reg)
                    begin
                        min_y_reg <= lo_new;
                        max_y_reg <= hi_new;
                    end
                    else
                    begin
                        min_x_reg <= lo_new;
                        max_x_reg <= hi_new;
                    end
                    root_last_reg <= 1'b1;
                    if (ax.a_zero)
                    begin
                        if (!ax.b_zero)
                        begin
                            n_reg     <= neg_cc;
                            den_reg   <= two_cb;
                            state_reg <= S_DSTART;
                        end
                        else if (ax.c_zero)
                        begin
                            t_reg     <= T_HALF;
                            eacc_reg  <= EA_W'(ax.ca);
                            estep_reg <= '0;
                            state_reg <= S_ESTART;
                        end
                        else
                        begin
                            state_reg <= S_NEXT;
                        end
                    end
                    else
                    begin
                        it_req_reg.op <= IT_MUL;
                        it_req_reg.a  <= cb_mag;
                        it_req_reg.b  <= cb_mag;
                        state_reg     <= S_MSQ;
                    end
                end

                S_MSQ:
                begin
                    if (it_rsp.done)
                    begin
                        sq_reg        <= it_rsp.result;
                        it_req_reg.op <= IT_MUL;
                        it_req_reg.a  <= ca_mag;
                        it_req_reg.b  <= cc_mag;
                        state_reg     <= S_MPR;
                    end
                end

                S_MPR:
                begin
                    if (it_rsp.done)
                    begin
                        if (!prod_neg && sq_less)
                        begin
                            state_reg <= S_NEXT;
                        end
                        else if (d_val == '0)
                        begin
                            n_reg         <= neg_cb;
                            den_reg       <= ax.ca;
                            root_last_reg <= 1'b1;
                            state_reg     <= S_DSTART;
                        end
                        else
                        begin
                            it_req_reg.op <= IT_SQRT;
                            it_req_reg.a  <= d_val;
                            it_req_reg.b  <= '0;
                            state_reg     <= S_SQRT;
                        end
                    end
                end

                S_SQRT:
                begin
                    if (it_rsp.done)
                    begin
                        s_reg         <= N_W'(it_rsp.result);
                        n_reg         <= neg_cb + N_W'(it_rsp.result);
                        den_reg       <= ax.ca;
                        root_last_reg <= 1'b0;
                        state_reg     <= S_DSTART;
                    end
                end

                S_DSTART:
                begin
                    it_req_reg.op <= IT_DIV;
                    it_req_reg.a  <= n_mag;
                    it_req_reg.b  <= den_mag;
                    state_reg     <= S_DIV;
                end

                S_DIV:
                begin
                    if (it_rsp.done)
                    begin
                        if (q_ok)
                        begin
                            t_reg     <= it_rsp.result[T_W-1:0];
                            eacc_reg  <= EA_W'(ax.ca);
                            estep_reg <= '0;
                            state_reg <= S_ESTART;
                        end
                        else if (root_last_reg)
                        begin
                            state_reg <= S_NEXT;
                        end
                        else
                        begin
                            n_reg         <= neg_cb - s_n;
                            root_last_reg <= 1'b1;
                            state_reg     <= S_DSTART;
                        end
                    end
                end

                S_ESTART:
                begin
                    it_req_reg.op <= IT_MUL;
                    it_req_reg.a  <= eacc_mag;
                    it_req_reg.b  <= IT_W'(t_reg);
                    state_reg     <= S_EMUL;
                end

                S_EMUL:
                begin
                    if (it_rsp.done)
                    begin
                        if (estep_reg == 2'd2)
                        begin
                            if (axis_reg)
                            begin
                                min_y_reg <= lo_new;
                                max_y_reg <= hi_new;
                            end
                            else
                            begin
                                min_x_reg <= lo_new;
                                max_x_reg <= hi_new;
                            end
                            if (root_last_reg)
                            begin
                                state_reg <= S_NEXT;
                            end
                            else
                            begin
                                n_reg         <= neg_cb - s_n;
                                root_last_reg <= 1'b1;
                                state_reg     <= S_DSTART;
                            end
                        end
                        else
                        begin
                            eacc_reg  <= eacc_new;
                            estep_reg <= estep_reg + 1'b1;
                            state_reg <= S_ESTART;
                        end
                    end
                end

                S_NEXT:
                begin
                    if (!axis_reg)
                    begin
                        axis_reg  <= 1'b1;
                        state_reg <= S_ENDS;
                    end
                    else if (job_reg.last)
                    begin
                        state_reg <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end

                S_EMIT:
                begin
                    if (!box_valid_reg || !box_stall)
                    begin
                        box_reg.box_min_x <= min_x_reg;
                        box_reg.box_min_y <= min_y_reg;
                        box_reg.box_max_x <= max_x_reg;
                        box_reg.box_max_y <= max_y_reg;
                        box_valid_reg     <= 1'b1;
                        min_x_reg         <= ACC_MIN_INIT;
                        min_y_reg         <= ACC_MIN_INIT;
                        max_x_reg         <= ACC_MAX_INIT;
                        max_y_reg         <= ACC_MAX_INIT;
                        state_reg         <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
